@@ design/lcbm_pkg.sv @@
// shared types and constants of the latched pattern-bank mapper
`timescale 1ns / 1ps

package lcbm_pkg;

    typedef enum logic [1:0] {
        MODE_CPU_READ  = 2'd0,
        MODE_CPU_WRITE = 2'd1,
        MODE_PPU_READ  = 2'd2,
        MODE_PPU_WRITE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ROM_NONE    = 2'd0,
        ROM_PROGRAM = 2'd1,
        ROM_PATTERN = 2'd2
    } rom_sel_t;

    // configuration register indexes
    localparam logic REG_PRG_BANK_COUNT = 1'b0;
    localparam logic REG_CHR_BANK_COUNT = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [4:0] PRG_COUNT_RST = 5'd16;
    localparam logic [5:0] CHR_COUNT_RST = 6'd32;

    localparam logic [4:0] LOW_FD_RST  = 5'd0;
    localparam logic [4:0] LOW_FE_RST  = 5'd1;
    localparam logic [4:0] HIGH_FD_RST = 5'd2;
    localparam logic [4:0] HIGH_FE_RST = 5'd3;

    // pattern-space tile rows that flip the latches
    localparam logic [7:0] LATCH_FD_ROW = 8'hFD;
    localparam logic [7:0] LATCH_FE_ROW = 8'hFE;

    // cpu register windows by address bits 14:12 (with bit 15 set)
    localparam logic [2:0] WIN_PRG_SELECT = 3'b010;
    localparam logic [2:0] WIN_LOW_FD     = 3'b011;
    localparam logic [2:0] WIN_LOW_FE     = 3'b100;
    localparam logic [2:0] WIN_HIGH_FD    = 3'b101;
    localparam logic [2:0] WIN_HIGH_FE    = 3'b110;
    localparam logic [2:0] WIN_MIRROR     = 3'b111;

    // fixed program banks sit at count-4+window, modulo 32
    localparam logic [4:0] PRG_FIXED_OFFSET = 5'd28;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic        claimed;
        rom_sel_t    rom_select;
        logic [16:0] rom_address;
        logic        bank_valid;
        logic        mirror_horizontal;
    } res_t;

    typedef struct packed {
        logic [4:0] prg_bank_count;
        logic [5:0] chr_bank_count;
    } cfg_t;

    typedef struct packed {
        logic [3:0] prg_select;
        logic [4:0] low_fd_bank;
        logic [4:0] low_fe_bank;
        logic [4:0] high_fd_bank;
        logic [4:0] high_fe_bank;
        logic       low_latch_is_fe;
        logic       high_latch_is_fe;
        logic       mirroring;
    } map_state_t;

endpackage

@@ design/latched_chr_bank_mapper_unit.sv @@
// top level of the latched pattern-bank cartridge mapper
// path: a request is held in the input register, mapped, and offered from the result register
// throughput: one access per cycle while results drain; the input register, mapping logic and
// result register form a two-stage pipeline that advances whenever the result slot frees
// reset: asynchronous active-low; bank registers 0/1/2/3, both latches on FE,
// vertical mirroring, program select 0, bank counts 16 and 32, pipeline empty
`timescale 1ns / 1ps

module latched_chr_bank_mapper_unit
    import lcbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output res_t                  rsp,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // input stage
    logic in_valid_reg;
    req_t in_item_reg;
    // result stage
    logic out_valid_reg;
    res_t out_item_reg;

    cfg_t cfg;
    res_t res_next;
    logic advance;

    // the result slot takes a new result when empty or when its transfer completes
    assign advance   = in_valid_reg & (~out_valid_reg | rsp_ready);
    // input register frees as its item moves on: a new transfer each cycle unless rsp stalls
    assign req_ready = ~in_valid_reg | advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    lcbm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // mapper state is updated as the item leaves the input stage, so the
    // following item always sees the registers and latches this one left
    lcbm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (in_item_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            in_item_reg <= req;
        if (advance)
            out_item_reg <= res_next;
    end

    // an empty input stage always takes a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> req_ready)
        else $error("input stage empty but request not ready");

    // an accepted request lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> in_valid_reg)
        else $error("accepted request lost");

    // an unclaimed access never points into a rom
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.claimed) |->
            (rsp.rom_select == ROM_NONE && rsp.rom_address == 17'd0 && !rsp.bank_valid))
        else $error("unclaimed access carries a rom address");

    // a stalled result waits while the input stage holds its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready && in_valid_reg) |=> in_valid_reg)
        else $error("item dropped while result stalled");

endmodule

@@ design/lcbm_cfg.sv @@
// apb configuration registers: program and pattern bank counts
`timescale 1ns / 1ps

module lcbm_cfg
    import lcbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_count <= PRG_COUNT_RST;
            cfg_reg.chr_bank_count <= CHR_COUNT_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_PRG_BANK_COUNT)
                cfg_reg.prg_bank_count <= pwdata[4:0];
            else
                cfg_reg.chr_bank_count <= pwdata[5:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PRG_BANK_COUNT)
            prdata = {27'd0, cfg_reg.prg_bank_count};
        else
            prdata = {26'd0, cfg_reg.chr_bank_count};
    end

endmodule

@@ design/lcbm_core.sv @@
// mapper state registers and the translation of one bus access
`timescale 1ns / 1ps

module lcbm_core
    import lcbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t req,
    input  cfg_t cfg,
    output res_t res
);

    map_state_t state_reg;
    map_state_t state_next;

    always_comb
    begin
        logic [4:0] bank;
        logic [1:0] window;
        logic [7:0] row;

        state_next = state_reg;
        res        = '0;
        bank       = '0;
        window     = req.bus_address[14:13];
        row        = req.bus_address[11:4];

        case (req.mode)
            MODE_CPU_READ:
            begin
                if (req.bus_address[15])
                begin
                    if (window == 2'd0)
                        bank = {1'b0, state_reg.prg_select};
                    else
                        bank = cfg.prg_bank_count + PRG_FIXED_OFFSET + {3'd0, window};
                    res.claimed     = 1'b1;
                    res.rom_select  = ROM_PROGRAM;
                    res.rom_address = {bank[3:0], req.bus_address[12:0]};
                    res.bank_valid  = bank < cfg.prg_bank_count;
                end
            end
            MODE_CPU_WRITE:
            begin
                if (req.bus_address[15])
                begin
                    res.claimed = 1'b1;
                    case (req.bus_address[14:12])
                        WIN_PRG_SELECT: state_next.prg_select   = req.write_data[3:0];
                        WIN_LOW_FD:     state_next.low_fd_bank  = req.write_data[4:0];
                        WIN_LOW_FE:     state_next.low_fe_bank  = req.write_data[4:0];
                        WIN_HIGH_FD:    state_next.high_fd_bank = req.write_data[4:0];
                        WIN_HIGH_FE:    state_next.high_fe_bank = req.write_data[4:0];
                        WIN_MIRROR:     state_next.mirroring    = req.write_data[0];
                        default:        ;
                    endcase
                end
            end
            MODE_PPU_READ:
            begin
                if (req.bus_address[15:13] == 3'd0)
                begin
                    if (row == LATCH_FD_ROW || row == LATCH_FE_ROW)
                    begin
                        if (req.bus_address[12])
                            state_next.high_latch_is_fe = (row == LATCH_FE_ROW);
                        else
                            state_next.low_latch_is_fe = (row == LATCH_FE_ROW);
                    end
                    if (req.bus_address[12])
                        bank = state_next.high_latch_is_fe ? state_reg.high_fe_bank
                                                           : state_reg.high_fd_bank;
                    else
                        bank = state_next.low_latch_is_fe ? state_reg.low_fe_bank
                                                          : state_reg.low_fd_bank;
                    res.claimed     = 1'b1;
                    res.rom_select  = ROM_PATTERN;
                    res.rom_address = {bank, req.bus_address[11:0]};
                    res.bank_valid  = {1'b0, bank} < cfg.chr_bank_count;
                end
            end
            default:
            begin
            end
        endcase

        res.mirror_horizontal = state_next.mirroring;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prg_select       <= '0;
            state_reg.low_fd_bank      <= LOW_FD_RST;
            state_reg.low_fe_bank      <= LOW_FE_RST;
            state_reg.high_fd_bank     <= HIGH_FD_RST;
            state_reg.high_fe_bank     <= HIGH_FE_RST;
            state_reg.low_latch_is_fe  <= 1'b1;
            state_reg.high_latch_is_fe <= 1'b1;
            state_reg.mirroring        <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule
